[sv/hwsfir_pkg.sv]
// ----------------------------------------------------------------------------
// hwsfir_pkg - shared definitions for the windowed-sinc low-pass fir
// Default sizes, the word-kind codes and the control struct of the tap cells.
// ----------------------------------------------------------------------------
package hwsfir_pkg;

	localparam int FILTER_ORDER = 40;
	localparam int SAMPLE_BITS  = 16;
	localparam int COEF_BITS    = 18;
	localparam int IDX_BITS     = 5;

	// kind of an input word, carried on tuser
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

[sv/hwsfir_cell.sv]
// ----------------------------------------------------------------------------
// hwsfir_cell - one tap of the folded symmetric delay line
// Holds the two samples at one tap distance and that distance's coefficient.
// Samples move one cell per shift, the low side toward the centre cell and
// the high side away from it; the pair product is registered every cycle.
// ----------------------------------------------------------------------------
module hwsfir_cell #(
	parameter int SAMPLE_BITS = hwsfir_pkg::SAMPLE_BITS,
	parameter int COEF_BITS   = hwsfir_pkg::COEF_BITS,
	parameter bit CENTER      = 1'b0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hwsfir_pkg::cell_ctl_t               ctl,
	input  logic signed [SAMPLE_BITS-1:0]       lo_in,
	input  logic signed [SAMPLE_BITS-1:0]       hi_in,
	output logic signed [SAMPLE_BITS-1:0]       lo_out,
	output logic signed [SAMPLE_BITS-1:0]       hi_out,
	input  logic                                coef_we,
	input  logic signed [COEF_BITS-1:0]         coef_in,
	output logic signed [SAMPLE_BITS+COEF_BITS:0] prod_s2
);

	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [COEF_BITS-1:0]   coef_q;
	logic signed [SAMPLE_BITS:0]   pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			hi_q   <= '0;
			coef_q <= '0;
		end else begin
			if (ctl.shift) begin
				lo_q <= lo_in;
				hi_q <= hi_in;
			end else if (ctl.clear) begin
				lo_q <= '0;
				hi_q <= '0;
			end
			if (coef_we) begin
				coef_q <= coef_in;
			end
		end
	end

	// the centre cell holds one sample and hands it to the high side
	assign lo_out = ctl.clear ? '0 : lo_q;
	assign hi_out = ctl.clear ? '0 : (CENTER ? lo_q : hi_q);

	assign pair = (SAMPLE_BITS+1)'(lo_q) + (SAMPLE_BITS+1)'(hi_q);

	always_ff @(posedge clk) begin
		prod_s2 <= (SAMPLE_BITS+COEF_BITS+1)'(coef_q * pair);
	end

endmodule

[sv/hwsfir_adder_tree.sv]
// ----------------------------------------------------------------------------
// hwsfir_adder_tree - registered binary adder tree
// Sums the tap products, one register level per tree level, with valid and
// last flags travelling alongside.
// ----------------------------------------------------------------------------
module hwsfir_adder_tree #(
	parameter int LEAVES = hwsfir_pkg::FILTER_ORDER / 2,
	parameter int IN_W   = hwsfir_pkg::SAMPLE_BITS + hwsfir_pkg::COEF_BITS + 1,
	parameter int OUT_W  = IN_W + $clog2(LEAVES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_last,
	input  logic signed [IN_W-1:0]  leaf [LEAVES],
	output logic                    out_valid,
	output logic                    out_last,
	output logic signed [OUT_W-1:0] sum
);

	localparam int LVLS = $clog2(LEAVES);
	localparam int BASE = 2 ** LVLS;

	logic signed [OUT_W-1:0] leaf_ext [BASE];
	logic signed [OUT_W-1:0] node [1:BASE-1];
	logic [LVLS-1:0]         v_q;
	logic [LVLS-1:0]         l_q;

	for (genvar i = 0; i < BASE; i++) begin : g_leaf
		if (i < LEAVES) begin : g_used
			assign leaf_ext[i] = OUT_W'(leaf[i]);
		end else begin : g_pad
			assign leaf_ext[i] = '0;
		end
	end

	// heap order: node n adds children 2n and 2n+1
	for (genvar n = 1; n < BASE; n++) begin : g_node
		if (2 * n >= BASE) begin : g_bottom
			always_ff @(posedge clk) begin
				node[n] <= leaf_ext[2*n-BASE] + leaf_ext[2*n+1-BASE];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node[n] <= node[2*n] + node[2*n+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q[0] <= in_valid;
			for (int d = 1; d < LVLS; d++) begin
				v_q[d] <= v_q[d-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		l_q[0] <= in_last;
		for (int d = 1; d < LVLS; d++) begin
			l_q[d] <= l_q[d-1];
		end
	end

	assign out_valid = v_q[LVLS-1];
	assign out_last  = l_q[LVLS-1];
	assign sum       = node[1];

endmodule

[sv/hwsfir_out_fifo.sv]
// ----------------------------------------------------------------------------
// hwsfir_out_fifo - result buffer in front of the master port
// Small register fifo; the writer keeps a credit count, so it never overflows.
// ----------------------------------------------------------------------------
module hwsfir_out_fifo #(
	parameter int W     = hwsfir_pkg::SAMPLE_BITS + 1,
	parameter int DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem [DEPTH];
	logic [AW:0]  wr_ptr_q;
	logic [AW:0]  rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_valid && rd_ready) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

	assign rd_valid = (wr_ptr_q != rd_ptr_q);
	assign rd_data  = mem[rd_ptr_q[AW-1:0]];

endmodule

[sv/hann_windowed_sinc_lowpass_fir.sv]
// ----------------------------------------------------------------------------
// hann_windowed_sinc_lowpass_fir - symmetric windowed-sinc low-pass fir
// Folded chain of tap cells, registered adder tree, rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries two kinds of word, told apart by tuser. A load word
//   (tuser 0) writes the coefficient of one tap distance, 0 being the centre;
//   an index past the last distance is ignored. A sample word (tuser 1) shifts
//   one sample into the delay line. Once FILTER_ORDER/2-1 samples of a series
//   went before it, each sample produces one filtered word on m_axis, centred
//   FILTER_ORDER/2-1 samples back. A sample with tlast starts a flush that
//   shifts zeros in, emits every pending word, marks the final one with tlast
//   and then clears the line. Throughput: one word per cycle while
//   s_axis_tready is high; it is low during a flush.
//   A result reaches m_axis through the sample registers of the cells, the
//   product register, the adder tree levels and the output fifo.
//   The output fifo holds 2**$clog2($clog2(FILTER_ORDER/2)+4) words (16);
//   when that many results are in flight or waiting, s_axis_tready drops
//   until m_axis takes one. Reset clears samples, coefficients and the fifo.
// ----------------------------------------------------------------------------
module hann_windowed_sinc_lowpass_fir #(
	parameter int FILTER_ORDER = hwsfir_pkg::FILTER_ORDER,
	parameter int SAMPLE_BITS  = hwsfir_pkg::SAMPLE_BITS,
	parameter int COEF_BITS    = hwsfir_pkg::COEF_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// coef_index, coef_value, sample
	input  logic [((hwsfir_pkg::IDX_BITS+COEF_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// action
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// filtered
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam int IDX_BITS   = hwsfir_pkg::IDX_BITS;
	localparam int HALF       = FILTER_ORDER / 2;
	localparam int CENTRE     = HALF - 1;
	localparam int LVLS       = $clog2(HALF);
	localparam int PROD_W     = SAMPLE_BITS + COEF_BITS + 1;
	localparam int ACC_W      = PROD_W + LVLS;
	localparam int SHR        = COEF_BITS - 1;
	localparam int RES_W      = ACC_W - SHR;
	localparam int SEEN_W     = $clog2(HALF + 1);
	localparam int STEP_W     = $clog2(CENTRE + 1);
	localparam int FIFO_DEPTH = 2 ** $clog2(LVLS + 4);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int OUT_DW     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (COEF_BITS - 2);

	logic [IDX_BITS-1:0]          coef_index;
	logic signed [COEF_BITS-1:0]  coef_value;
	logic signed [SAMPLE_BITS-1:0] sample;

	logic s_acc, samp_acc, load_acc, m_acc;
	logic credit_ok, fstep, shift, flush_end, emit;
	logic signed [SAMPLE_BITS-1:0] shift_val;

	logic               flush_q;
	logic               clear_q;
	logic [STEP_W-1:0]  step_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic               emit_s1;
	logic               last_s1;
	logic               v_s2;
	logic               last_s2;

	hwsfir_pkg::cell_ctl_t cell_ctl;

	logic signed [SAMPLE_BITS-1:0] lo_o    [HALF];
	logic signed [SAMPLE_BITS-1:0] hi_o    [HALF];
	logic signed [SAMPLE_BITS-1:0] lo_feed [HALF];
	logic signed [SAMPLE_BITS-1:0] hi_feed [HALF];
	logic signed [PROD_W-1:0]      prod_s2 [HALF];

	logic                    tree_valid, tree_last;
	logic signed [ACC_W-1:0] tree_sum;
	logic [ACC_W-1:0]        acc_rnd;
	logic [RES_W-1:0]        res;
	logic                    in_range;
	logic [SAMPLE_BITS-1:0]  sat;
	logic [SAMPLE_BITS:0]    fifo_rd;

	assign coef_index = s_axis_tdata[IDX_BITS-1:0];
	assign coef_value = s_axis_tdata[IDX_BITS+COEF_BITS-1 -: COEF_BITS];
	assign sample     = s_axis_tdata[IDX_BITS+COEF_BITS+SAMPLE_BITS-1 -: SAMPLE_BITS];

	assign credit_ok     = (out_cnt_q < CNT_W'(FIFO_DEPTH));
	assign s_axis_tready = !flush_q && credit_ok;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign samp_acc      = s_acc && (s_axis_tuser == hwsfir_pkg::ACT_SAMPLE);
	assign load_acc      = s_acc && (s_axis_tuser == hwsfir_pkg::ACT_LOAD);
	assign m_acc         = m_axis_tvalid && m_axis_tready;

	// flush steps shift zeros, one per cycle while there is room for the result
	assign fstep     = flush_q && credit_ok;
	assign shift     = samp_acc || fstep;
	assign shift_val = samp_acc ? sample : '0;
	assign flush_end = fstep && (step_q == STEP_W'(CENTRE));
	assign emit      = shift && (seen_q >= SEEN_W'(CENTRE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q   <= 1'b0;
			clear_q   <= 1'b0;
			step_q    <= '0;
			seen_q    <= '0;
			out_cnt_q <= '0;
			emit_s1   <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			clear_q <= flush_end;
			if (samp_acc && s_axis_tlast) begin
				flush_q <= 1'b1;
				step_q  <= STEP_W'(1);
			end else if (fstep) begin
				if (flush_end) begin
					flush_q <= 1'b0;
				end
				step_q <= step_q + 1'b1;
			end

			if (flush_end) begin
				seen_q <= '0;
			end else if (shift && (seen_q != SEEN_W'(HALF))) begin
				seen_q <= seen_q + 1'b1;
			end

			unique case ({emit, m_acc})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase

			emit_s1 <= emit;
			v_s2    <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= flush_end;
		last_s2 <= last_s1;
	end

	// the line is cleared in the cycle after the last flush shift, once its
	// products are captured; a sample taken in that cycle enters a clean line
	assign cell_ctl.shift = shift;
	assign cell_ctl.clear = clear_q;

	for (genvar k = 0; k < HALF; k++) begin : g_tap
		if (k == CENTRE) begin : g_lo_entry
			assign lo_feed[k] = shift_val;
		end else begin : g_lo_link
			assign lo_feed[k] = lo_o[k+1];
		end
		if (k == 0) begin : g_hi_entry
			assign hi_feed[k] = '0;
		end else begin : g_hi_link
			assign hi_feed[k] = hi_o[k-1];
		end

		hwsfir_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.COEF_BITS   (COEF_BITS),
			.CENTER      (k == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.lo_in   (lo_feed[k]),
			.hi_in   (hi_feed[k]),
			.lo_out  (lo_o[k]),
			.hi_out  (hi_o[k]),
			.coef_we (load_acc && (32'(coef_index) == k)),
			.coef_in (coef_value),
			.prod_s2 (prod_s2[k])
		);
	end

	hwsfir_adder_tree #(
		.LEAVES (HALF),
		.IN_W   (PROD_W),
		.OUT_W  (ACC_W)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_last   (last_s2),
		.leaf      (prod_s2),
		.out_valid (tree_valid),
		.out_last  (tree_last),
		.sum       (tree_sum)
	);

	// round half up, drop the fraction, saturate to the sample range
	assign acc_rnd  = tree_sum + RND;
	assign res      = acc_rnd[ACC_W-1:SHR];
	assign in_range = (&res[RES_W-1:SAMPLE_BITS-1]) || !(|res[RES_W-1:SAMPLE_BITS-1]);
	assign sat      = in_range ? res[SAMPLE_BITS-1:0]
	                           : {res[RES_W-1], {(SAMPLE_BITS-1){~res[RES_W-1]}}};

	hwsfir_out_fifo #(
		.W     (SAMPLE_BITS + 1),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tree_valid),
		.wr_data  ({tree_last, sat}),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (fifo_rd)
	);

	assign m_axis_tdata = OUT_DW'(fifo_rd[SAMPLE_BITS-1:0]);
	assign m_axis_tlast = fifo_rd[SAMPLE_BITS];

endmodule

[sv/hwsfir_checker.sv]
// ----------------------------------------------------------------------------
// hwsfir_checker - port-level checks for the windowed-sinc fir
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module hwsfir_checker #(
	parameter int FILTER_ORDER = hwsfir_pkg::FILTER_ORDER,
	parameter int SAMPLE_BITS  = hwsfir_pkg::SAMPLE_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic s_axis_tuser,
	input logic s_axis_tlast,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic m_axis_tlast
);

	localparam int HALF = FILTER_ORDER / 2;

	logic last_sample_acc;

	assign last_sample_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast
	                         && (s_axis_tuser == hwsfir_pkg::ACT_SAMPLE);

	// a stalled result word holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// the flush after a closing sample blocks the input for all its zero shifts
	a_flush_stall: assert property (@(posedge clk) disable iff (!arst_n)
		last_sample_acc |=> (!s_axis_tready) [*HALF-1])
		else $error("input taken during flush");

	// nothing to deliver while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result word shown during reset");

endmodule

bind hann_windowed_sinc_lowpass_fir hwsfir_checker #(
	.FILTER_ORDER (FILTER_ORDER),
	.SAMPLE_BITS  (SAMPLE_BITS)
) u_hwsfir_checker (.*);
